[rtl/midi_byte_stream_parser_assert.svh]
// Assertion macros for the MIDI byte stream parser.
// Each macro takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef MIDI_BYTE_STREAM_PARSER_ASSERT_SVH
`define MIDI_BYTE_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MBSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MBSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MBSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/mbsp_pkg.sv]
package mbsp_pkg;

    // SysEx payload bytes stored per run before further bytes are dropped
    localparam int unsigned SYSEX_LIMIT = 128;
    localparam logic [7:0]  SX_LIMIT    = 8'(SYSEX_LIMIT);

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_EMPTY  = 4'b0001,
        PH_STATUS = 4'b0010,
        PH_DATA0  = 4'b0100,
        PH_SYSEX  = 4'b1000
    } t_phase;

    // Running type codes (status high nibble, bits 6:4)
    localparam logic [2:0] RT_CC      = 3'd3;
    localparam logic [2:0] RT_PROG    = 3'd4;
    localparam logic [2:0] RT_CHPRESS = 3'd5;
    localparam logic [2:0] RT_SYSCOM  = 3'd7;

    // Message type codes on the result
    localparam logic [3:0] MT_SYSCOM   = 4'd7;
    localparam logic [3:0] MT_REALTIME = 4'd8;
    localparam logic [3:0] MT_CHMODE   = 4'd9;

    // System common subtypes
    localparam logic [2:0] SUB_SYSEX    = 3'd0;
    localparam logic [2:0] SUB_MTC_QF   = 3'd1;
    localparam logic [2:0] SUB_SONG_POS = 3'd2;
    localparam logic [2:0] SUB_SONG_SEL = 3'd3;

    // Special bytes
    localparam logic [7:0] BYTE_EOX    = 8'hF7;
    localparam logic [6:0] CC_MODE_MIN = 7'd120;

    // Stream widths
    localparam int unsigned TDATA_W = 40;
    localparam int unsigned TUSER_W = 4;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] rtype;
        logic [3:0] chan;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic [2:0] sub;
        logic [7:0] sx_cnt;
    } t_state;

    typedef struct packed {
        logic [3:0] msg_type;
        logic [3:0] chan;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic [2:0] sub;
        logic [7:0] sx_byte;
        logic [7:0] sx_cnt;
        logic       sx_end;
    } t_result;

    // Completed message from the held fields
    function automatic t_result put_message(t_state s);
        t_result r;
        r.data_first  = s.data_first;
        r.data_second = s.data_second;
        r.sx_byte     = '0;
        r.sx_cnt      = '0;
        r.sx_end      = 1'b0;
        if (s.rtype == RT_CC && s.data_first >= CC_MODE_MIN) begin
            r.msg_type = MT_CHMODE;
            r.chan     = s.chan;
            r.sub      = s.sub;
        end else if (s.rtype == RT_SYSCOM) begin
            r.msg_type = MT_SYSCOM;
            r.chan     = '0;
            r.sub      = s.sub;
        end else begin
            r.msg_type = {1'b0, s.rtype};
            r.chan     = s.chan;
            r.sub      = '0;
        end
        return r;
    endfunction

endpackage

[rtl/mbsp_decode.sv]
// Next-state and result logic for one received byte
module mbsp_decode (
    input  mbsp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    output mbsp_pkg::t_state  o_state,
    output logic              o_res_valid,
    output mbsp_pkg::t_result o_res
);
    import mbsp_pkg::*;

    logic     is_status;
    logic     one_byte;
    t_state   fd_state;
    t_result  sx_res;

    assign is_status = i_byte[7];

    // First data byte handling, shared by the empty and status phases
    always_comb begin
        fd_state            = i_state;
        fd_state.data_first = i_byte[6:0];
        if (i_state.rtype == RT_CC && i_byte[6:0] >= CC_MODE_MIN) begin
            fd_state.sub = i_byte[2:0];
        end
        one_byte = (i_state.rtype == RT_PROG) || (i_state.rtype == RT_CHPRESS) ||
                   (i_state.rtype == RT_SYSCOM &&
                    (i_state.sub == SUB_MTC_QF || i_state.sub == SUB_SONG_SEL));
        fd_state.phase = one_byte ? PH_EMPTY : PH_DATA0;
    end

    // SysEx result template
    always_comb begin
        sx_res             = '0;
        sx_res.msg_type    = MT_SYSCOM;
        sx_res.data_first  = i_state.data_first;
        sx_res.data_second = i_state.data_second;
    end

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = put_message(i_state);
        case (i_state.phase)
            PH_EMPTY: begin
                if (!is_status) begin
                    o_state     = fd_state;
                    o_res_valid = one_byte;
                    o_res       = put_message(fd_state);
                end else if (i_byte inside {[8'hF8:8'hFF]}) begin
                    // real-time: immediate, held fields untouched
                    o_res_valid    = 1'b1;
                    o_res.msg_type = MT_REALTIME;
                    o_res.chan     = '0;
                    o_res.sub      = i_byte[2:0];
                end else if (i_byte[6:4] != RT_SYSCOM) begin
                    o_state.rtype = i_byte[6:4];
                    o_state.chan  = i_byte[3:0];
                    o_state.phase = PH_STATUS;
                end else begin
                    o_state.rtype = RT_SYSCOM;
                    o_state.chan  = '0;
                    o_state.sub   = i_byte[2:0];
                    if (i_byte[2:0] == SUB_SYSEX) begin
                        o_state.sx_cnt = '0;
                        o_state.phase  = PH_SYSEX;
                    end else if (i_byte[2:0] > SUB_SONG_SEL) begin
                        o_res_valid = 1'b1;
                        o_res       = put_message(o_state);
                    end else begin
                        o_state.phase = PH_STATUS;
                    end
                end
            end
            PH_STATUS: begin
                if (is_status) begin
                    o_state.phase = PH_EMPTY;
                end else begin
                    o_state     = fd_state;
                    o_res_valid = one_byte;
                    o_res       = put_message(fd_state);
                end
            end
            PH_DATA0: begin
                o_state.phase = PH_EMPTY;
                if (!is_status) begin
                    o_state.data_second = i_byte[6:0];
                    o_res_valid         = 1'b1;
                    o_res               = put_message(o_state);
                end
            end
            PH_SYSEX: begin
                o_res = sx_res;
                if (i_byte == BYTE_EOX) begin
                    o_state.phase = PH_EMPTY;
                    o_res_valid   = 1'b1;
                    o_res.sx_cnt  = i_state.sx_cnt;
                    o_res.sx_end  = 1'b1;
                end else if (i_state.sx_cnt < SX_LIMIT) begin
                    o_state.sx_cnt = i_state.sx_cnt + 8'd1;
                    o_res_valid    = 1'b1;
                    o_res.sx_byte  = i_byte;
                    o_res.sx_cnt   = i_state.sx_cnt + 8'd1;
                end
            end
            default: begin
                o_state.phase = PH_EMPTY;
            end
        endcase
    end

endmodule

[rtl/midi_byte_stream_parser.sv]
// Channel | Dir | Payload
// s_axis  | in  | tdata[7:0] rx_byte
// m_axis  | out | tdata: channel, data_first, data_second, sub_type, sysex_byte,
//         |     | sysex_count; tuser: msg_type; tlast: sysex_end
//
// One byte per clock sustained while m_axis_tready stays high. A byte passes an input
// register, then one decode step updates parser state and loads the result register;
// a byte with no result just updates state. A stalled result holds in the result
// register while one more byte waits in the input register. i_rst_n is synchronous,
// active low, and clears the valid flags and parser state; the payload
// registers are not reset.
module midi_byte_stream_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] channel, [10:4] data_first, [17:11] data_second, [20:18] sub_type,
    // [28:21] sysex_byte, [36:29] sysex_count, [39:37] zero
    output logic [mbsp_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [mbsp_pkg::TUSER_W-1:0]  m_axis_tuser,  // [3:0] msg_type
    output logic                          m_axis_tlast   // sysex_end
);
    import mbsp_pkg::*;
    `include "midi_byte_stream_parser_assert.svh"

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_res;
    logic       n_res_valid;
    logic       advance;

    // Decode step moves when the result register is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    mbsp_decode u_decode (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .o_state     (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_res)
    );

    // Control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.phase       <= PH_EMPTY;
            r_state.rtype       <= '0;
            r_state.chan        <= '0;
            r_state.data_first  <= '0;
            r_state.data_second <= '0;
            r_state.sub         <= '0;
            r_state.sx_cnt      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= n_res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.sx_cnt, r_out.sx_byte, r_out.sub,
                            r_out.data_second, r_out.data_first, r_out.chan};
    assign m_axis_tuser  = r_out.msg_type;
    assign m_axis_tlast  = r_out.sx_end;

    // SysEx counter saturates at the limit
    `MBSP_ASSERT_IMP(a_sx_cnt_limit, i_clk, i_rst_n, 1'b1, r_state.sx_cnt <= SX_LIMIT, "sysex count above limit")
    // End-of-SysEx result is system common with no payload byte
    `MBSP_ASSERT_IMP(a_eox_result, i_clk, i_rst_n, r_out_valid && r_out.sx_end, r_out.msg_type == MT_SYSCOM && r_out.sx_byte == 8'd0, "bad end-of-sysex result")
    // Channel-mode result carries a mode controller number
    `MBSP_ASSERT_IMP(a_chmode_result, i_clk, i_rst_n, r_out_valid && r_out.msg_type == MT_CHMODE, r_out.data_first >= CC_MODE_MIN && r_out.sub == r_out.data_first[2:0], "bad channel-mode result")
    // Input stalls only when both stages are full and output is blocked
    `MBSP_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, r_in_valid && r_out_valid && !m_axis_tready, "input stalled without cause")
    // A held byte stays in the input register until the decode step takes it
    `MBSP_ASSERT_NXT(a_no_lost_byte, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid, "buffered byte lost")

endmodule

[bench/midi_byte_stream_parser_checker.sv]
// Watches both stream channels of the MIDI parser, predicts every result from
// the accepted bytes and compares them in order.
module midi_byte_stream_parser_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [mbsp_pkg::TDATA_W-1:0]  i_out_data,
    input  logic [mbsp_pkg::TUSER_W-1:0]  i_out_user,
    input  logic                          i_out_last,
    output int                            o_mismatch_count,
    output int                            o_pending,
    output int                            o_checked_count,
    output logic [9:0]                    o_types_seen
);
    import mbsp_pkg::*;

    // first real-time byte; everything from here up completes at once
    localparam logic [7:0] REALTIME_MIN = 8'hF8;
    localparam logic [2:0] SUB_TUNE_MIN = 3'd4;

    // parser shadow state
    t_phase     phase;
    logic [2:0] run_type;
    logic [3:0] chan_q;
    logic [6:0] first_q;
    logic [6:0] second_q;
    logic [2:0] sub_q;
    logic [7:0] sysex_cnt_q;

    t_result msg_expect_q[$];
    int      mismatches;
    int      checked;

    // result built from the held fields for the current running type
    function automatic t_result held_message();
        t_result r;
        r             = '0;
        r.data_first  = first_q;
        r.data_second = second_q;
        if (run_type == RT_CC && first_q >= CC_MODE_MIN) begin
            r.msg_type = MT_CHMODE;
            r.chan     = chan_q;
            r.sub      = sub_q;
        end else if (run_type == RT_SYSCOM) begin
            r.msg_type = MT_SYSCOM;
            r.sub      = sub_q;
        end else begin
            r.msg_type = 4'(run_type);
            r.chan     = chan_q;
        end
        return r;
    endfunction

    // first data byte; one-byte messages complete here
    function automatic bit take_first_data(input logic [7:0] b, output t_result r);
        logic single;
        r       = '0;
        first_q = b[6:0];
        if (run_type == RT_CC && first_q >= CC_MODE_MIN)
            sub_q = 3'(first_q - CC_MODE_MIN);
        single = run_type == RT_PROG || run_type == RT_CHPRESS ||
                 (run_type == RT_SYSCOM && (sub_q == SUB_MTC_QF || sub_q == SUB_SONG_SEL));
        if (single) begin
            phase = PH_EMPTY;
            r     = held_message();
            return 1'b1;
        end
        phase = PH_DATA0;
        return 1'b0;
    endfunction

    // one received byte; returns 1 when it completes a result
    function automatic bit decode_midi_byte(input logic [7:0] b, output t_result r);
        r = '0;
        case (phase)
            PH_EMPTY: begin
                if (!b[7])
                    return take_first_data(b, r);
                if (b >= REALTIME_MIN) begin
                    r.msg_type    = MT_REALTIME;
                    r.data_first  = first_q;
                    r.data_second = second_q;
                    r.sub         = b[2:0];
                    return 1'b1;
                end
                run_type = b[6:4];
                if (run_type != RT_SYSCOM) begin
                    chan_q = b[3:0];
                    phase  = PH_STATUS;
                    return 1'b0;
                end
                chan_q = '0;
                sub_q  = b[2:0];
                if (sub_q == SUB_SYSEX) begin
                    sysex_cnt_q = '0;
                    phase       = PH_SYSEX;
                    return 1'b0;
                end
                if (sub_q >= SUB_TUNE_MIN) begin
                    r = held_message();
                    return 1'b1;
                end
                phase = PH_STATUS;
                return 1'b0;
            end
            PH_STATUS: begin
                // a status byte here drops the partial message
                if (b[7]) begin
                    phase = PH_EMPTY;
                    return 1'b0;
                end
                return take_first_data(b, r);
            end
            PH_DATA0: begin
                phase = PH_EMPTY;
                if (b[7])
                    return 1'b0;
                second_q = b[6:0];
                r        = held_message();
                return 1'b1;
            end
            default: begin
                // inside SysEx every byte but EOX is payload
                r.msg_type    = MT_SYSCOM;
                r.data_first  = first_q;
                r.data_second = second_q;
                if (b == BYTE_EOX) begin
                    phase    = PH_EMPTY;
                    r.sx_cnt = sysex_cnt_q;
                    r.sx_end = 1'b1;
                    return 1'b1;
                end
                if (sysex_cnt_q < SX_LIMIT) begin
                    sysex_cnt_q = sysex_cnt_q + 8'd1;
                    r.sx_byte   = b;
                    r.sx_cnt    = sysex_cnt_q;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // compare on the output side first, then predict from the input side
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            phase       = PH_EMPTY;
            run_type    = '0;
            chan_q      = '0;
            first_q     = '0;
            second_q    = '0;
            sub_q       = '0;
            sysex_cnt_q = '0;
            msg_expect_q.delete();
            mismatches  = 0;
            checked     = 0;
            o_types_seen <= '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                // tdata: [3:0] channel, [10:4] data_first, [17:11] data_second,
                // [20:18] sub_type, [28:21] sysex_byte, [36:29] sysex_count
                got.msg_type    = i_out_user[3:0];
                got.chan        = i_out_data[3:0];
                got.data_first  = i_out_data[10:4];
                got.data_second = i_out_data[17:11];
                got.sub         = i_out_data[20:18];
                got.sx_byte     = i_out_data[28:21];
                got.sx_cnt      = i_out_data[36:29];
                got.sx_end      = i_out_last;
                if (msg_expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got tuser %0h tdata %0h",
                             $time, i_out_user, i_out_data);
                    mismatches++;
                end else begin
                    want = msg_expect_q.pop_front();
                    check_field("msg_type", 32'(want.msg_type), 32'(got.msg_type));
                    check_field("channel", 32'(want.chan), 32'(got.chan));
                    check_field("data_first", 32'(want.data_first), 32'(got.data_first));
                    check_field("data_second", 32'(want.data_second),
                                32'(got.data_second));
                    check_field("sub_type", 32'(want.sub), 32'(got.sub));
                    check_field("sysex_byte", 32'(want.sx_byte), 32'(got.sx_byte));
                    check_field("sysex_count", 32'(want.sx_cnt), 32'(got.sx_cnt));
                    check_field("sysex_end", 32'(want.sx_end), 32'(got.sx_end));
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (decode_midi_byte(i_in_byte, want)) begin
                    msg_expect_q.push_back(want);
                    o_types_seen[want.msg_type] <= 1'b1;
                end
            end
        end
        o_pending        <= msg_expect_q.size();
        o_mismatch_count <= mismatches;
        o_checked_count  <= checked;
    end

endmodule

[bench/midi_byte_stream_parser_tb.sv]
// Stimulus and verdict for the MIDI parser; checking lives in the checker.
module midi_byte_stream_parser_tb;
    import mbsp_pkg::*;

    // voice kinds not named in the package
    localparam logic [2:0] VK_NOTE_OFF = 3'd0;
    localparam logic [2:0] VK_NOTE_ON  = 3'd1;
    localparam logic [2:0] VK_PITCH    = 3'd6;
    localparam logic [3:0] SYS_NIBBLE  = 4'hF;
    localparam logic [2:0] SUB_TUNE_REQ = 3'd6;
    localparam logic [7:0] SYSEX_START = {SYS_NIBBLE, 1'b0, SUB_SYSEX};
    localparam logic [7:0] RT_CLOCK    = 8'hF8;
    localparam logic [7:0] RT_RESET    = 8'hFF;
    localparam logic [7:0] DATA_MAX    = 8'h7F;
    localparam int         SETTLE_CYCLES = 4;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] rx_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;   // channel, data_first, data_second, sub_type,
                                          // sysex_byte, sysex_count from bit 0 up
    logic [TUSER_W-1:0]   m_axis_tuser;   // [3:0] msg_type
    logic                 m_axis_tlast;   // sysex_end

    int         mismatch_count;
    int         pending_msgs;
    int         checked_msgs;
    logic [9:0] types_seen;

    int  bytes_sent;
    int  run_len;      // data bytes a running-status message would need
    bit  src_idle_on;
    bit  sink_idle_on;
    logic [7:0] directed_bytes [25];

    midi_byte_stream_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    midi_byte_stream_parser_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .i_in_ready       (s_axis_tready),
        .i_in_byte        (s_axis_tdata),
        .i_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .i_out_data       (m_axis_tdata),
        .i_out_user       (m_axis_tuser),
        .i_out_last       (m_axis_tlast),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_msgs),
        .o_checked_count  (checked_msgs),
        .o_types_seen     (types_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #3000000;
        $display("midi_byte_stream_parser_tb: FAIL");
        $finish;
    end

    // result side: ready in random bursts, steady when idling is off
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_idle_on && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16) - 1) @(posedge i_clk);
            end
        end
    end

    // one request, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_data();
        return 8'($urandom_range(0, 127));
    endfunction

    // stop sending and wait for every expected result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_msgs != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sysex(input int len);
        int         i;
        logic [7:0] b;
        send_byte(SYSEX_START);
        for (i = 0; i < len; i++) begin
            // mostly data bytes, some status bytes that count as payload
            if ($urandom_range(0, 7) == 0) begin
                b = 8'($urandom_range(128, 255));
                if (b == BYTE_EOX)
                    b = RT_CLOCK;
            end else begin
                b = rand_data();
            end
            send_byte(b);
        end
        send_byte(BYTE_EOX);
        run_len = 2;
    endtask

    // one well-formed message with random content, or a broken one, or noise
    task automatic send_random_message();
        int         pick;
        int         n;
        int         i;
        logic [2:0] kind;
        logic [2:0] sub;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 15 && run_len != 0) begin
            for (i = 0; i < run_len; i++)
                send_byte(rand_data());
        end else if (pick < 55) begin
            kind = 3'($urandom_range(0, 6));
            send_byte({1'b1, kind, 4'($urandom_range(0, 15))});
            n = (kind == RT_PROG || kind == RT_CHPRESS) ? 1 : 2;
            run_len = n;
            if ($urandom_range(0, 9) == 0)
                n--;
            for (i = 0; i < n; i++) begin
                b = rand_data();
                // lean on the channel-mode range of control changes
                if (i == 0 && kind == RT_CC && $urandom_range(0, 1) == 1)
                    b = {1'b0, CC_MODE_MIN} + 8'($urandom_range(0, 7));
                send_byte(b);
            end
        end else if (pick < 65) begin
            sub = 3'($urandom_range(1, 7));
            send_byte({SYS_NIBBLE, 1'b0, sub});
            if (sub == SUB_MTC_QF || sub == SUB_SONG_SEL) begin
                n       = 1;
                run_len = 1;
            end else begin
                n       = (sub == SUB_SONG_POS) ? 2 : 0;
                run_len = 2;
            end
            if (n > 0 && $urandom_range(0, 9) == 0)
                n--;
            for (i = 0; i < n; i++)
                send_byte(rand_data());
        end else if (pick < 75) begin
            if ($urandom_range(0, 29) == 0)
                send_sysex($urandom_range(SYSEX_LIMIT - 8, SYSEX_LIMIT + 8));
            else
                send_sysex($urandom_range(0, 12));
        end else if (pick < 85) begin
            send_byte(RT_CLOCK + 8'($urandom_range(0, 7)));
        end else begin
            send_byte(8'($urandom_range(0, 255)));
            run_len = 2;
        end
    endtask

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_rst_n       <= 1'b0;
        bytes_sent   = 0;
        run_len      = 2;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        directed_bytes = '{
            8'h00, DATA_MAX,                                   // running note off from reset
            {1'b1, VK_NOTE_ON, 4'hF}, 8'h3C, DATA_MAX,          // note on, top channel
            {1'b1, RT_PROG, 4'h5}, DATA_MAX, 8'h00,             // one-byte, then running
            {1'b1, RT_CC, 4'h3}, {1'b0, CC_MODE_MIN}, 8'h00,    // lowest channel-mode code
            DATA_MAX, DATA_MAX,                                 // highest one under running
            RT_RESET,
            {1'b1, VK_PITCH, 4'h0}, 8'h40,                      // cut short by a status
            {1'b1, VK_NOTE_OFF, 4'h0},
            {SYS_NIBBLE, 1'b0, SUB_SONG_SEL}, 8'h05,
            {SYS_NIBBLE, 1'b0, SUB_TUNE_REQ}, 8'h11, 8'h22,     // running after sys common
            SYSEX_START, {1'b1, VK_NOTE_OFF, 4'h0}, BYTE_EOX    // status byte as payload
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);
        wait_drained();

        // SysEx past the storage limit
        send_sysex(SYSEX_LIMIT + $urandom_range(1, 8));
        while (bytes_sent < 325)
            send_random_message();
        wait_drained();

        src_idle_on = 1'b0;
        while (bytes_sent < 525)
            send_random_message();
        sink_idle_on = 1'b0;
        while (bytes_sent < 775)
            send_random_message();
        wait_drained();

        $display("covered %0d input bytes and %0d checked results", bytes_sent, checked_msgs);
        $display("message types seen, one bit per type code: %b", types_seen);
        if (mismatch_count == 0) begin
            $display("midi_byte_stream_parser_tb: PASS");
        end else begin
            $display("midi_byte_stream_parser_tb: FAIL");
        end
        $finish;
    end

endmodule
